// File: rtl/fpcf_pkg.sv
// Shared types and constants for the follower point cloud filter.
// Holds the item structs, register indexes, pose word indexes and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpcf_pkg;

    // Word and field widths fixed by the item formats.
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned POSE_WORDS = 11;
    localparam int unsigned TAB_FRAC   = 24;
    localparam int unsigned TAB_LEN    = 24;
    // Angle accumulator width: 180 degrees plus the table sum with 24 fraction bits.
    localparam int unsigned ZW         = 36;
    localparam int unsigned PADDR_W    = 5;

    // Configuration register indexes (byte address divided by four).
    localparam logic [2:0] REG_YAW_LOW     = 3'd0;
    localparam logic [2:0] REG_YAW_HIGH    = 3'd1;
    localparam logic [2:0] REG_FOLLOW_RAD  = 3'd2;
    localparam logic [2:0] REG_HEIGHT_LOW  = 3'd3;
    localparam logic [2:0] REG_HEIGHT_HIGH = 3'd4;

    // Request types.
    localparam logic REQ_POSE  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    // Pose word indexes.
    localparam int unsigned POSE_R00 = 0;
    localparam int unsigned POSE_R10 = 1;
    localparam int unsigned POSE_R20 = 2;
    localparam int unsigned POSE_R01 = 3;
    localparam int unsigned POSE_R11 = 4;
    localparam int unsigned POSE_R21 = 5;
    localparam int unsigned POSE_TX  = 6;
    localparam int unsigned POSE_TY  = 7;
    localparam int unsigned POSE_TZ  = 8;
    localparam int unsigned POSE_OX  = 9;
    localparam int unsigned POSE_OY  = 10;

    typedef logic [POSE_WORDS-1:0][WORD_W-1:0] t_pose;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         word_index;
        logic signed [31:0] word_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               batch_end;
    } t_in_item;

    typedef struct packed {
        logic               remove_point;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               out_last;
    } t_out_item;

    // Data that rides along the pipeline beside the angle computation.
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               last;
        logic               dist_ok;
        logic               z_ok;
        logic               at_origin;
    } t_side;

    // Arctangent of 2^-k in degrees with 24 fraction bits.
    function automatic logic signed [ZW-1:0] atan_deg(input int unsigned k);
        logic signed [ZW-1:0] v;
        begin
            unique case (k)
                0:  v = 36'sd754974720;
                1:  v = 36'sd445687602;
                2:  v = 36'sd235489088;
                3:  v = 36'sd119537938;
                4:  v = 36'sd60000934;
                5:  v = 36'sd30029717;
                6:  v = 36'sd15018523;
                7:  v = 36'sd7509720;
                8:  v = 36'sd3754917;
                9:  v = 36'sd1877466;
                10: v = 36'sd938734;
                11: v = 36'sd469367;
                12: v = 36'sd234684;
                13: v = 36'sd117342;
                14: v = 36'sd58671;
                15: v = 36'sd29336;
                16: v = 36'sd14668;
                17: v = 36'sd7334;
                18: v = 36'sd3667;
                19: v = 36'sd1833;
                20: v = 36'sd917;
                21: v = 36'sd458;
                22: v = 36'sd229;
                23: v = 36'sd115;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/fpcf_front.sv
// Front pipeline: translation, rotation into robot frame, distance and height tests.
// Four stages ending in the pre-rotated CORDIC vector. Depends on fpcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpcf_front #(
    parameter int unsigned COORD_FRAC_BITS = 16,
    parameter int unsigned XW              = 53
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_valid,
    input  fpcf_pkg::t_in_item        i_item,
    input  fpcf_pkg::t_pose           i_pose,
    input  wire  [61:0]               i_radius_sq,
    input  wire  signed [31:0]        i_height_low,
    input  wire  signed [31:0]        i_height_high,
    output logic                      o_valid,
    output logic signed [XW-1:0]      o_x,
    output logic signed [XW-1:0]      o_y,
    output logic signed [fpcf_pkg::ZW-1:0] o_z,
    output fpcf_pkg::t_side           o_side
);
    import fpcf_pkg::*;

    localparam int unsigned SW = XW - 2;

    // Stage 1 registers.
    logic                     r_v1;
    logic signed [32:0]       r_d [3];
    logic signed [32:0]       r_e [2];
    logic signed [31:0]       r_rot [6];
    t_side                    r_s1;
    // Stage 2 registers.
    logic                     r_v2;
    logic signed [64:0]       r_prod [6];
    logic [65:0]              r_sq [2];
    t_side                    r_s2;
    // Stage 3 registers.
    logic                     r_v3;
    logic signed [SW-1:0]     r_rx;
    logic signed [SW-1:0]     r_ry;
    t_side                    r_s3;
    // Stage 4 registers.
    logic                     r_v4;
    logic signed [XW-1:0]     r_x4;
    logic signed [XW-1:0]     r_y4;
    logic signed [ZW-1:0]     r_z4;
    t_side                    r_s4;

    logic [32:0]              mag [2];
    logic [66:0]              dist_sum;
    logic [63:0]              dist_sat;
    logic signed [SW-1:0]     rx_sum;
    logic signed [SW-1:0]     ry_sum;
    logic signed [XW-1:0]     rx_ext;
    logic signed [XW-1:0]     ry_ext;
    t_side                    n_s3;
    t_side                    n_s4;

    // Valid bits move with the global stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage 1: differences, rotation snapshot and height test.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= 33'(i_item.point_x) - 33'($signed(i_pose[POSE_TX]));
            r_d[1] <= 33'(i_item.point_y) - 33'($signed(i_pose[POSE_TY]));
            r_d[2] <= 33'(i_item.point_z) - 33'($signed(i_pose[POSE_TZ]));
            r_e[0] <= 33'(i_item.point_x) - 33'($signed(i_pose[POSE_OX]));
            r_e[1] <= 33'(i_item.point_y) - 33'($signed(i_pose[POSE_OY]));
            for (int k = 0; k < 6; k++) begin
                r_rot[k] <= $signed(i_pose[k]);
            end
            r_s1.px        <= i_item.point_x;
            r_s1.py        <= i_item.point_y;
            r_s1.pz        <= i_item.point_z;
            r_s1.last      <= i_item.batch_end;
            r_s1.dist_ok   <= 1'b0;
            r_s1.z_ok      <= (i_item.point_z >= i_height_low) &&
                              (i_item.point_z <= i_height_high);
            r_s1.at_origin <= 1'b0;
        end
    end

    // Magnitudes of the offsets from the follow origin.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            mag[k] = r_e[k][32] ? 33'(-r_e[k]) : 33'(r_e[k]);
        end
    end

    // Stage 2: rotation products and squares.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[POSE_R00] <= 65'(r_rot[POSE_R00]) * 65'(r_d[0]);
            r_prod[POSE_R10] <= 65'(r_rot[POSE_R10]) * 65'(r_d[1]);
            r_prod[POSE_R20] <= 65'(r_rot[POSE_R20]) * 65'(r_d[2]);
            r_prod[POSE_R01] <= 65'(r_rot[POSE_R01]) * 65'(r_d[0]);
            r_prod[POSE_R11] <= 65'(r_rot[POSE_R11]) * 65'(r_d[1]);
            r_prod[POSE_R21] <= 65'(r_rot[POSE_R21]) * 65'(r_d[2]);
            r_sq[0]          <= 66'(mag[0]) * 66'(mag[0]);
            r_sq[1]          <= 66'(mag[1]) * 66'(mag[1]);
            r_s2             <= r_s1;
        end
    end

    // Floor-shifted product sums and the saturated squared distance.
    always_comb begin
        rx_sum = SW'(r_prod[POSE_R00] >>> COORD_FRAC_BITS)
               + SW'(r_prod[POSE_R10] >>> COORD_FRAC_BITS)
               + SW'(r_prod[POSE_R20] >>> COORD_FRAC_BITS);
        ry_sum = SW'(r_prod[POSE_R01] >>> COORD_FRAC_BITS)
               + SW'(r_prod[POSE_R11] >>> COORD_FRAC_BITS)
               + SW'(r_prod[POSE_R21] >>> COORD_FRAC_BITS);
        dist_sum = 67'(r_sq[0]) + 67'(r_sq[1]);
        dist_sat = (dist_sum[66:64] != 3'd0) ? '1 : dist_sum[63:0];
        n_s3         = r_s2;
        n_s3.dist_ok = dist_sat <= 64'(i_radius_sq);
    end

    // Stage 3: robot frame coordinates and distance test.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx <= rx_sum;
            r_ry <= ry_sum;
            r_s3 <= n_s3;
        end
    end

    // Stage 4: fold the left half plane onto the right and seed the angle.
    always_comb begin
        rx_ext = XW'(r_rx);
        ry_ext = XW'(r_ry);
        n_s4           = r_s3;
        n_s4.at_origin = (r_rx == '0) && (r_ry == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4 <= n_s4;
            if (r_rx[SW-1]) begin
                r_x4 <= -rx_ext;
                r_y4 <= -ry_ext;
                r_z4 <= r_ry[SW-1] ? -(ZW'(180) <<< TAB_FRAC) : (ZW'(180) <<< TAB_FRAC);
            end else begin
                r_x4 <= rx_ext;
                r_y4 <= ry_ext;
                r_z4 <= '0;
            end
        end
    end

    assign o_valid = r_v4;
    assign o_x     = r_x4;
    assign o_y     = r_y4;
    assign o_z     = r_z4;
    assign o_side  = r_s4;

endmodule

`default_nettype wire

// File: rtl/fpcf_cordic_cell.sv
// One CORDIC vectoring cell: a single micro-rotation toward y = 0, registered.
// Cells are chained, one per step. Depends on fpcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpcf_cordic_cell #(
    parameter int unsigned STEP = 0,
    parameter int unsigned XW   = 53
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire                            i_valid,
    input  wire  signed [XW-1:0]           i_x,
    input  wire  signed [XW-1:0]           i_y,
    input  wire  signed [fpcf_pkg::ZW-1:0] i_z,
    input  fpcf_pkg::t_side                i_side,
    output logic                           o_valid,
    output logic signed [XW-1:0]           o_x,
    output logic signed [XW-1:0]           o_y,
    output logic signed [fpcf_pkg::ZW-1:0] o_z,
    output fpcf_pkg::t_side                o_side
);
    import fpcf_pkg::*;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] ang;

    assign xs  = i_x >>> STEP;
    assign ys  = i_y >>> STEP;
    assign ang = atan_deg(STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // Rotate clockwise when y is non-negative, else counterclockwise.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            if (!i_y[XW-1]) begin
                o_x <= i_x + ys;
                o_y <= i_y - xs;
                o_z <= i_z + ang;
            end else begin
                o_x <= i_x - ys;
                o_y <= i_y + xs;
                o_z <= i_z - ang;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/follower_point_cloud_filter_top.sv
// Top level of the follower point cloud filter: pose table, register port,
// front pipeline, CORDIC cell chain and output register.
// Depends on fpcf_pkg, fpcf_front and fpcf_cordic_cell.
//
//  channel  | direction | signals                          | payload
//  ---------+-----------+----------------------------------+-----------
//  input    | in        | i_in_valid / o_in_ready          | t_in_item
//  output   | out       | o_out_valid / i_out_ready        | t_out_item
//  config   | in        | psel penable pwrite paddr pwdata | 32-bit regs
//
// One item is accepted per cycle while the output is not stalled. A point passes through
// four front stages, one cell per CORDIC step and one output stage.
// Pose loads update the table at their transfer and produce no result.
// A stall on the output freezes the whole pipeline; o_in_ready follows it.
// Synchronous active-low reset clears valid bits and pose table and sets config registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module follower_point_cloud_filter_top #(
    parameter int unsigned CORDIC_STEPS    = 16,
    parameter int unsigned COORD_FRAC_BITS = 16,
    parameter int unsigned ANGLE_FRAC_BITS = 7
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  fpcf_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output fpcf_pkg::t_out_item            o_out_data,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [fpcf_pkg::PADDR_W-1:0]   paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import fpcf_pkg::*;

    localparam int unsigned SW = 67 - COORD_FRAC_BITS;
    localparam int unsigned XW = SW + 2;
    localparam int unsigned RSH = TAB_FRAC - ANGLE_FRAC_BITS;

    logic                 en;
    logic                 in_xfer;
    logic                 cfg_wr;
    logic [2:0]           cfg_idx;

    t_pose                r_pose;
    logic signed [15:0]   r_yaw_low;
    logic signed [15:0]   r_yaw_high;
    logic [30:0]          r_follow_radius;
    logic signed [31:0]   r_height_low;
    logic signed [31:0]   r_height_high;
    logic [61:0]          r_radius_sq;

    logic                 c_valid [CORDIC_STEPS+1];
    logic signed [XW-1:0] c_x     [CORDIC_STEPS+1];
    logic signed [XW-1:0] c_y     [CORDIC_STEPS+1];
    logic signed [ZW-1:0] c_z     [CORDIC_STEPS+1];
    t_side                c_side  [CORDIC_STEPS+1];

    logic signed [ZW-1:0] ang;
    logic                 yaw_ok;
    logic                 r_out_valid;
    t_out_item            r_out_data;

    // Global advance: the pipeline moves when the output register can take data.
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign in_xfer    = i_in_valid && en;

    // Register port decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_low       <= -16'sd23040;
            r_yaw_high      <= 16'sd23040;
            r_follow_radius <= '0;
            r_height_low    <= 32'sh8000_0000;
            r_height_high   <= 32'sh7FFF_FFFF;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_YAW_LOW:     r_yaw_low       <= pwdata[15:0];
                REG_YAW_HIGH:    r_yaw_high      <= pwdata[15:0];
                REG_FOLLOW_RAD:  r_follow_radius <= pwdata[30:0];
                REG_HEIGHT_LOW:  r_height_low    <= pwdata;
                REG_HEIGHT_HIGH: r_height_high   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (cfg_idx)
            REG_YAW_LOW:     prdata = 32'(r_yaw_low);
            REG_YAW_HIGH:    prdata = 32'(r_yaw_high);
            REG_FOLLOW_RAD:  prdata = 32'(r_follow_radius);
            REG_HEIGHT_LOW:  prdata = r_height_low;
            REG_HEIGHT_HIGH: prdata = r_height_high;
            default:         prdata = '0;
        endcase
    end

    // Squared follow radius, refreshed every cycle from the register.
    always_ff @(posedge i_clk) begin
        r_radius_sq <= 62'(r_follow_radius) * 62'(r_follow_radius);
    end

    // Pose table written by load items at their transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose <= '0;
        end else if (in_xfer && (i_in_data.req_type == REQ_POSE) &&
                     (i_in_data.word_index < 4'(POSE_WORDS))) begin
            r_pose[i_in_data.word_index] <= i_in_data.word_value;
        end
    end

    fpcf_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .XW              (XW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (in_xfer && (i_in_data.req_type == REQ_POINT)),
        .i_item        (i_in_data),
        .i_pose        (r_pose),
        .i_radius_sq   (r_radius_sq),
        .i_height_low  (r_height_low),
        .i_height_high (r_height_high),
        .o_valid       (c_valid[0]),
        .o_x           (c_x[0]),
        .o_y           (c_y[0]),
        .o_z           (c_z[0]),
        .o_side        (c_side[0])
    );

    // Chain of CORDIC cells, one micro-rotation each.
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        fpcf_cordic_cell #(
            .STEP (g),
            .XW   (XW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // Round the angle to the output precision and test the open yaw window.
    always_comb begin
        ang = (c_z[CORDIC_STEPS] + (ZW'(1) <<< (RSH - 1))) >>> RSH;
        if (c_side[CORDIC_STEPS].at_origin) begin
            ang = '0;
        end
        yaw_ok = (ang > ZW'(r_yaw_low)) && (ang < ZW'(r_yaw_high));
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data.remove_point <= yaw_ok && c_side[CORDIC_STEPS].dist_ok &&
                                       c_side[CORDIC_STEPS].z_ok;
            r_out_data.out_x        <= c_side[CORDIC_STEPS].px;
            r_out_data.out_y        <= c_side[CORDIC_STEPS].py;
            r_out_data.out_z        <= c_side[CORDIC_STEPS].pz;
            r_out_data.out_last     <= c_side[CORDIC_STEPS].last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // A stalled result blocks new transfers.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // A pose load of the TX word lands in the table.
    a_pose_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_data.req_type == REQ_POSE) && (i_in_data.word_index == 4'd6))
        |=> (r_pose[POSE_TX] == $past(i_in_data.word_value)))
        else $error("pose word not stored");

    // A stalled result keeps its flag.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_data.remove_point))
        else $error("result changed while stalled");

    // Reset restores the yaw window.
    a_reset_yaw: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> ((r_yaw_low == -16'sd23040) && (r_yaw_high == 16'sd23040)))
        else $error("yaw registers not reset");
`endif

endmodule

`default_nettype wire
